// File: src/crc8_framed_sentence_decoder_assert.svh
`ifndef CRC8_FRAMED_SENTENCE_DECODER_ASSERT_SVH
`define CRC8_FRAMED_SENTENCE_DECODER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CFSD_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// implication checked in the next cycle
`define CFSD_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: src/cfsd_pkg.sv
`timescale 1ns / 1ps
package cfsd_pkg;
  localparam int BufferBytesDefault = 16;
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcOfDelim = 8'hFC;
  localparam logic [7:0] Delim = 8'h24;

  typedef enum logic [2:0] {
    KIND_HEALTH = 3'd0, KIND_WIND = 3'd1, KIND_ATT = 3'd2,
    KIND_DATA = 3'd3, KIND_MENU = 3'd4, KIND_OTHER = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_DECODED = 2'd0, ST_MISMATCH = 2'd1, ST_CRC_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic [15:0] value_d;
    logic [15:0] value_e;
    logic [15:0] value_f;
    logic [15:0] value_g;
    logic [31:0] pass_count;
    logic [31:0] fail_count;
    logic [31:0] byte_count;
  } result_t;

  // closed sentence as handed from front to back
  typedef struct packed {
    logic [14:0][7:0] bytes;
    logic [5:0]       len;
    logic             crc_ok;
    logic [31:0]      byte_count;
  } sentence_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) v = v[7] ? ((v << 1) ^ CrcPoly) : (v << 1);
    return v;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction
endpackage

// File: src/cfsd_stream_if.sv
`timescale 1ns / 1ps
interface cfsd_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/cfsd_front.sv
`timescale 1ns / 1ps
module cfsd_front #(
  parameter int BUFFER_BYTES = cfsd_pkg::BufferBytesDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  output logic                  in_ready,
  output logic                  sn_valid,
  output cfsd_pkg::sentence_t   sn,
  input  logic                  sn_ready
);
  import cfsd_pkg::*;
  localparam int Cap = BUFFER_BYTES - 1;
  localparam int LW = $clog2(BUFFER_BYTES);

  logic [14:0][7:0] buf_q;
  logic [7:0] last_q;
  logic [LW-1:0] fill;
  logic [7:0] crc_all, crc_but_last;
  logic [31:0] bytes_total;
  logic take, closing;

  // a closing delimiter needs room in the queue; other bytes never stall
  assign closing = (in_byte == Delim) && (fill != '0);
  assign in_ready = !closing || sn_ready;
  assign take = in_valid && in_ready;
  assign sn_valid = in_valid && closing;

  always_comb begin
    sn.bytes = buf_q;
    sn.len = 6'(fill);
    sn.crc_ok = crc_but_last == last_q;
    sn.byte_count = bytes_total + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      crc_all <= CrcOfDelim;
      crc_but_last <= CrcOfDelim;
      bytes_total <= '0;
    end else if (take) begin
      bytes_total <= bytes_total + 32'd1;
      if (in_byte == Delim) begin
        fill <= '0;
        crc_all <= CrcOfDelim;
        crc_but_last <= CrcOfDelim;
      end else if (fill < LW'(Cap)) begin
        // only the first 15 bytes are ever decoded, the last one is the check byte
        if (fill < LW'(15)) buf_q[fill[3:0]] <= in_byte;
        last_q <= in_byte;
        fill <= fill + LW'(1);
        crc_but_last <= crc_all;
        crc_all <= crc_byte(crc_all, in_byte);
      end
    end
  end
endmodule

// File: src/cfsd_back.sv
`timescale 1ns / 1ps
module cfsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                sn_valid,
  input  cfsd_pkg::sentence_t sn,
  output logic                sn_ready,
  output logic                res_valid,
  output cfsd_pkg::result_t   res,
  input  logic                res_ready
);
  import cfsd_pkg::*;
  // two-entry queue between front and decode
  sentence_t q [2];
  logic [1:0] cnt;
  logic wp, rp;
  logic [31:0] passed, failed;
  logic push, pop;
  sentence_t s;
  result_t r;
  logic [7:0] t;

  assign sn_ready = cnt != 2'd2;
  assign push = sn_valid && sn_ready;
  assign pop = (cnt != 2'd0) && (!res_valid || res_ready);
  assign s = q[rp];
  assign t = s.bytes[0];

  always_comb begin
    r = '0;
    if (t == "S") r.kind = KIND_HEALTH;
    else if (t == "W" || t == "w") r.kind = KIND_WIND;
    else if (t == "A" || t == "a") r.kind = KIND_ATT;
    else if (t == "D" || t == "d") r.kind = KIND_DATA;
    else if (t == "M") r.kind = KIND_MENU;
    else r.kind = KIND_OTHER;
    r.pass_count = passed + {31'd0, s.crc_ok};
    r.fail_count = failed + {31'd0, !s.crc_ok};
    r.byte_count = s.byte_count;
    if (!s.crc_ok) r.status = ST_CRC_FAIL;
    else begin
      r.status = ST_MISMATCH;
      if (r.kind == KIND_HEALTH && s.len == 6'd5) begin
        r.status = ST_DECODED;
        r.value_a = {14'd0, s.bytes[1][7:6]};
        r.value_b = {8'd0, s.bytes[1] & 8'hFC};
        r.value_c = {15'd0, s.bytes[2][7]};
        r.value_d = {14'd0, s.bytes[2][5:4]};
        r.value_e = {12'd0, s.bytes[2][3:0]};
      end else if (r.kind == KIND_WIND && s.len == 6'd11) begin
        r.status = ST_DECODED;
        r.value_a = {s.bytes[1], s.bytes[2]};
        r.value_b = {8'd0, s.bytes[3]};
        r.value_c = {s.bytes[4], s.bytes[5]};
        r.value_d = {8'd0, s.bytes[6]};
        r.value_e = {s.bytes[7], s.bytes[8]};
      end else if (r.kind == KIND_ATT && s.len == 6'd10) begin
        r.status = ST_DECODED;
        r.value_a = {s.bytes[1], s.bytes[2]};
        r.value_b = sext8(s.bytes[3]);
        r.value_c = {s.bytes[4], s.bytes[5]};
        r.value_d = {s.bytes[6], s.bytes[7]};
      end else if (r.kind == KIND_DATA && s.len == 6'd15) begin
        r.status = ST_DECODED;
        r.value_a = {s.bytes[1], s.bytes[2]};
        r.value_b = {s.bytes[3], s.bytes[4]};
        r.value_c = {s.bytes[5], s.bytes[6]};
        r.value_d = {s.bytes[7], s.bytes[8]};
        r.value_e = sext8(s.bytes[9]);
        r.value_f = {8'd0, s.bytes[10]};
        r.value_g = {s.bytes[11], s.bytes[12]};
      end else if (r.kind == KIND_MENU && s.len == 6'd7) begin
        r.status = ST_DECODED;
        r.value_a = {8'd0, s.bytes[1]};
        r.value_b = {8'd0, s.bytes[2]};
        r.value_c = {8'd0, s.bytes[3]};
        r.value_d = {8'd0, s.bytes[4]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= sn;
    if (pop) res <= r;
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
      passed <= '0;
      failed <= '0;
      res_valid <= 1'b0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (push) wp <= !wp;
      if (pop) begin
        rp <= !rp;
        passed <= r.pass_count;
        failed <= r.fail_count;
        res_valid <= 1'b1;
      end else if (res_ready) res_valid <= 1'b0;
    end
  end
endmodule

// File: src/crc8_framed_sentence_decoder.sv
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | data byte (8 bits)
// out     | out | cfsd_pkg::result_t (kind, status, value_a..g, counts)
// one byte per cycle unless stalled; each result is queued, then registered
// the front stalls only on a closing delimiter when the two-entry queue is full
// output is one register, refilled in the cycle it is taken if a sentence waits
// rst clears buffer fill, counters, queue and output valid, and presets crc
module crc8_framed_sentence_decoder #(
  parameter int BUFFER_BYTES = cfsd_pkg::BufferBytesDefault
) (
  input logic clk,
  input logic rst,
  cfsd_stream_if.sink   in_ch,
  cfsd_stream_if.source out_ch
);
  import cfsd_pkg::*;
  `include "crc8_framed_sentence_decoder_assert.svh"

  logic sn_valid, sn_ready;
  sentence_t sn;
  result_t res;

  cfsd_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_byte(in_ch.data), .in_ready(in_ch.ready),
    .sn_valid, .sn, .sn_ready
  );

  cfsd_back u_back (
    .clk, .rst, .sn_valid, .sn, .sn_ready,
    .res_valid(out_ch.valid), .res, .res_ready(out_ch.ready)
  );

  assign out_ch.data = res;

  `CFSD_ASSERT_IMP(a_status_range, out_ch.valid,
                   res.status == ST_DECODED || res.status == ST_MISMATCH || res.status == ST_CRC_FAIL)
  `CFSD_ASSERT_IMP(a_fail_zero, out_ch.valid && res.status != ST_DECODED,
                   res.value_a == 16'd0 && res.value_g == 16'd0)
  `CFSD_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
